FILE: sv/assert_macros.svh
// Assertion macros for the RC frame parser RTL.
// Depends on nothing; included by the top level after its declarations.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/rcfp_pkg.sv
// Constants, codes and the CRC-8 step for the RC frame parser.
// No dependencies; imported by rc_frame_parser_with_failsafe.
package rcfp_pkg;

  localparam int RAW_W = 11;
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_MSB = 8'h80;
  localparam logic [7:0] MAX_LENGTH = 8'd62;
  localparam logic [11:0] CHANNEL_OFFSET = 12'd992;

  // Item commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_FRAME_TYPE = 2'd1;
  localparam logic [1:0] REG_FAILSAFE_TICKS = 2'd2;

  // Frame positions
  localparam logic [5:0] POS_HUNT = 6'd0;
  localparam logic [5:0] POS_LENGTH = 6'd1;
  localparam logic [5:0] POS_TYPE = 6'd2;
  localparam logic [5:0] POS_PAYLOAD = 6'd3;

  // Reset values of the registers
  localparam logic [7:0] RESET_DEVICE_ADDRESS = 8'd200;
  localparam logic [7:0] RESET_FRAME_TYPE = 8'd22;
  localparam logic [15:0] RESET_FAILSAFE_TICKS = 16'd1000;

  typedef logic [RAW_W-1:0] raw_channel_t;

  // CRC-8, MSB first, one byte per call
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/rc_frame_parser_with_failsafe.sv
// RC channel frame parser with failsafe timer.
// Result is registered on input transfer; one item per cycle unless out_ready holds the output.
// The byte/tick step, CRC and channel unpack all sit between the input port and
// the result register, which also acts as the output stage of the handshake.
// Reset (rst, synchronous) clears the parser, payload, channels and counter, and
// loads the register defaults: address 200, frame type 22, failsafe 1000 ticks.
module rc_frame_parser_with_failsafe
  import rcfp_pkg::*;
#(
  parameter int CHANNEL_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  channel_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [11:0] channel_value,
  output logic        link_valid,
  output logic        frame_accepted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * RAW_W + 7) / 8;
  localparam int PIDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CIDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // Configuration
  logic [7:0]  device_address;
  logic [7:0]  channels_frame_type;
  logic [15:0] failsafe_ticks;

  // Parser state
  logic [5:0]   byte_position, byte_position_next;
  logic [5:0]   frame_length, frame_length_next;
  logic [7:0]   running_crc, running_crc_next;
  logic [7:0]   type_byte, type_byte_next;
  logic [15:0]  failsafe_counter, failsafe_counter_next;
  logic [7:0]   payload_bytes [PAYLOAD_BYTES];
  raw_channel_t raw_channels [CHANNEL_COUNT];

  logic         in_fire;
  logic [7:0]   crc_step;
  logic [5:0]   payload_offset;
  logic         payload_write;
  logic         good_frame;

  logic [PAYLOAD_BYTES*8-1:0] payload_flat;
  raw_channel_t               unpacked [CHANNEL_COUNT];
  logic [CIDX_W+2:0]          sel_wide;
  logic [CIDX_W-1:0]          sel;
  logic                       sel_in_range;
  raw_channel_t               sel_raw;
  logic [11:0]                value_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address      <= RESET_DEVICE_ADDRESS;
      channels_frame_type <= RESET_FRAME_TYPE;
      failsafe_ticks      <= RESET_FAILSAFE_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        REG_FRAME_TYPE:     channels_frame_type <= cfg_data[7:0];
        REG_FAILSAFE_TICKS: failsafe_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flatten payload LSB-first and cut out the 11-bit channels
  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      payload_flat[i*8 +: 8] = payload_bytes[i];
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      unpacked[ch] = payload_flat[ch*RAW_W +: RAW_W];
    end
  end

  assign crc_step       = crc8_update(running_crc, data_byte);
  assign payload_offset = byte_position - POS_PAYLOAD;

  always_comb begin
    byte_position_next    = byte_position;
    frame_length_next     = frame_length;
    running_crc_next      = running_crc;
    type_byte_next        = type_byte;
    failsafe_counter_next = failsafe_counter;
    payload_write         = 1'b0;
    good_frame            = 1'b0;
    if (cmd == CMD_BYTE) begin
      if (byte_position == POS_HUNT) begin
        running_crc_next = 8'd0;
        if (data_byte == device_address) begin
          byte_position_next = POS_LENGTH;
        end
      end else if (byte_position == POS_LENGTH) begin
        if (data_byte > MAX_LENGTH) begin
          byte_position_next = POS_HUNT;
        end else begin
          frame_length_next  = data_byte[5:0];
          byte_position_next = POS_TYPE;
        end
      end else if ({1'b0, byte_position} < ({1'b0, frame_length} + 7'd1)) begin
        running_crc_next = crc_step;
        if (byte_position == POS_TYPE) begin
          type_byte_next = data_byte;
        end else if (int'(payload_offset) < PAYLOAD_BYTES) begin
          payload_write = 1'b1;
        end
        byte_position_next = byte_position + 6'd1;
      end else begin
        // CRC byte: check and close the frame
        running_crc_next = crc_step;
        if (type_byte == channels_frame_type && crc_step == 8'd0) begin
          good_frame            = 1'b1;
          failsafe_counter_next = failsafe_ticks;
        end
        byte_position_next = POS_HUNT;
      end
    end else if (failsafe_counter != 16'd0) begin
      failsafe_counter_next = failsafe_counter - 16'd1;
    end
  end

  // Result: selected channel as it stands after this item
  always_comb begin
    sel_wide     = (CIDX_W+3)'(channel_index);
    sel          = sel_wide[CIDX_W-1:0];
    sel_in_range = int'(channel_index) < CHANNEL_COUNT;
    sel_raw      = good_frame ? unpacked[sel] : raw_channels[sel];
    value_next   = sel_in_range ? ({1'b0, sel_raw} - CHANNEL_OFFSET) : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= POS_HUNT;
      frame_length     <= 6'd0;
      running_crc      <= 8'd0;
      type_byte        <= 8'd0;
      failsafe_counter <= 16'd0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        payload_bytes[i] <= 8'd0;
      end
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
        raw_channels[ch] <= '0;
      end
    end else if (in_fire) begin
      byte_position    <= byte_position_next;
      frame_length     <= frame_length_next;
      running_crc      <= running_crc_next;
      type_byte        <= type_byte_next;
      failsafe_counter <= failsafe_counter_next;
      if (payload_write) begin
        payload_bytes[payload_offset[PIDX_W-1:0]] <= data_byte;
      end
      if (good_frame) begin
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
          raw_channels[ch] <= unpacked[ch];
        end
      end
    end
  end

  // Output stage: load on input transfer, drop once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      channel_value  <= value_next;
      link_valid     <= failsafe_counter_next != 16'd0;
      frame_accepted <= good_frame;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_pos_bound, clk, rst, byte_position > frame_length + 6'd1, byte_position == POS_TYPE)
  `ASSERT_NEXT(a_tick_no_frame, clk, rst, in_fire && cmd == CMD_TICK, out_valid && !frame_accepted)
  `ASSERT_IMPLIES(a_accept_closes, clk, rst, out_valid && frame_accepted, byte_position == POS_HUNT)

endmodule
